@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every edge outside reset
`define RMRR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this edge, consequent at the next edge
`define RMRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rmrr_pkg.sv @@
// ----------------------------------------------------------------------------
// rmrr_pkg
// Types and fixed constants of the round-robin register mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rmrr_pkg;

	localparam int VAR_W = 5;   // variable id field
	localparam int REG_W = 5;   // physical register field
	localparam int PTR_W = 6;   // free pointer, may run one past the last register

	// victim search gives up after this many skips
	localparam logic [PTR_W-1:0] MAX_VICTIM_STEPS = 6'd32;

	typedef enum logic {
		CMD_GET   = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		EV_STORE      = 2'd0,
		EV_LOAD       = 2'd1,
		EV_GRANT      = 2'd2,
		EV_FLUSH_DONE = 2'd3
	} ev_kind_t;

	typedef struct packed {
		cmd_t             command;
		logic [VAR_W-1:0] var_id;
		logic [VAR_W-1:0] pin_result_var;
		logic             pin_op1_valid;
		logic [VAR_W-1:0] pin_op1_var;
		logic             pin_op2_valid;
		logic [VAR_W-1:0] pin_op2_var;
	} in_item_t;

	typedef struct packed {
		ev_kind_t         event_kind;
		logic [VAR_W-1:0] event_var;
		logic [REG_W-1:0] event_reg;
		logic             last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_VICTIM,
		ST_LOAD,
		ST_GRANT,
		ST_FL_RD,
		ST_FL_CHK,
		ST_FL_DONE
	} state_t;

	// strobes into the variable table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_en;
		logic clr_all;
	} vt_ctl_t;

endpackage

`default_nettype wire

@@ rtl/rmrr_if.sv @@
// ----------------------------------------------------------------------------
// rmrr_if
// Valid/ready channels for request items and event items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmrr_in_if;
	import rmrr_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface rmrr_out_if;
	import rmrr_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ rtl/rmrr_var_table.sv @@
// ----------------------------------------------------------------------------
// rmrr_var_table
// Variable to register map: mapped flags in flops, register numbers in a
// synchronous memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrr_var_table #(
	parameter int NUM_VARS = 32,
	parameter int VIDX_W   = 5
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  rmrr_pkg::vt_ctl_t        ctl,
	input  wire [VIDX_W-1:0]         rd_addr,
	input  wire [VIDX_W-1:0]         wr_addr,
	input  wire [rmrr_pkg::REG_W-1:0] wr_reg,
	input  wire [VIDX_W-1:0]         clr_addr,
	output logic                     rd_mapped,
	output logic [rmrr_pkg::REG_W-1:0] rd_reg
);
	import rmrr_pkg::*;

	logic [NUM_VARS-1:0] mapped_q;
	logic [REG_W-1:0]    mem [NUM_VARS];
	logic                rd_mapped_q;
	logic [REG_W-1:0]    rd_reg_q;

	// mapped flags: set on write, cleared singly on eviction, all on flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q    <= '0;
			rd_mapped_q <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				mapped_q <= '0;
			end else if (ctl.clr_en) begin
				mapped_q[clr_addr] <= 1'b0;
			end else if (ctl.wr_en) begin
				mapped_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_mapped_q <= mapped_q[rd_addr];
			end
		end
	end

	// register number storage
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_reg;
		end
		if (ctl.rd_en) begin
			rd_reg_q <= mem[rd_addr];
		end
	end

	assign rd_mapped = rd_mapped_q;
	assign rd_reg    = rd_reg_q;

endmodule

`default_nettype wire

@@ rtl/rmrr_reg_table.sv @@
// ----------------------------------------------------------------------------
// rmrr_reg_table
// Register to variable reverse map, one synchronous memory, read every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrr_reg_table #(
	parameter int NUM_REGS = 17,
	parameter int RIDX_W   = 5
) (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire [RIDX_W-1:0]           wr_addr,
	input  wire [rmrr_pkg::VAR_W-1:0]  wr_var,
	input  wire [RIDX_W-1:0]           rd_addr,
	output logic [rmrr_pkg::VAR_W-1:0] rd_var
);
	import rmrr_pkg::*;

	logic [VAR_W-1:0] mem [NUM_REGS];
	logic [VAR_W-1:0] rd_var_q;

	// holder storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_var;
		end
		rd_var_q <= mem[rd_addr];
	end

	assign rd_var = rd_var_q;

endmodule

`default_nettype wire

@@ rtl/register_map_round_robin_spill.sv @@
// ----------------------------------------------------------------------------
// register_map_round_robin_spill
// Maps variables onto physical registers FIRST_REG..LAST_REG with
// round-robin eviction and spill/load events; flush writes all back.
// ----------------------------------------------------------------------------
// One request item is handled at a time. A hit or an out-of-range variable
// gets its grant from the look state; a miss served from a never-used
// register passes the look, load and grant states; a miss that evicts
// passes look, victim, load and grant, the victim state skipping each
// pinned register under the victim pointer before its store event. Events
// go through the output register on evt; the last one returns the
// sequencer to idle at that same edge. Table reads are registered; the
// reverse table is searched one entry a cycle. A flush reads and then
// checks each variable, emitting a store for a mapped one from the check
// state, then ends with the done event. Back-pressure on evt holds every
// emitting state. The reverse table needs no clearing pass after reset.
`default_nettype none

module register_map_round_robin_spill #(
	parameter int NUM_VARS  = 32,
	parameter int FIRST_REG = 8,
	parameter int LAST_REG  = 24
) (
	input wire          clk,
	input wire          arst_n,
	rmrr_in_if.sink     cmd,
	rmrr_out_if.source  evt
);
	import rmrr_pkg::*;

	`include "assert_macros.svh"

	localparam int VIDX_W   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int NUM_REGS = LAST_REG - FIRST_REG + 1;
	localparam int RIDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	state_t            state_q, state_d;
	in_item_t          item_q;
	logic [REG_W-1:0]  reg_sel_q, reg_sel_d;
	logic [PTR_W-1:0]  next_free_q, next_free_d;
	logic [REG_W-1:0]  victim_q, victim_d;
	logic [PTR_W-1:0]  steps_q, steps_d;
	logic [VIDX_W-1:0] scan_q, scan_d;

	logic              oval_q;
	out_item_t         oitem_q;

	logic              accept, slot_free, emit;
	out_item_t         ev_item;

	vt_ctl_t           vt_ctl;
	logic [VIDX_W-1:0] vt_rd_addr, vt_clr_addr, var_idx;
	logic              vt_rd_mapped;
	logic [REG_W-1:0]  vt_rd_reg;

	logic              rt_wr_en;
	logic [RIDX_W-1:0] rt_wr_addr, rt_rd_addr;
	logic [VAR_W-1:0]  rt_rd_var;

	logic [VAR_W-1:0]  victim_var;
	logic              pinned, var_out_of_range;
	logic [REG_W-1:0]  victim_adv;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !oval_q || evt.ready;

	assign var_idx          = VIDX_W'(item_q.var_id);
	assign var_out_of_range = PTR_W'(item_q.var_id) >= PTR_W'(NUM_VARS);

	// victim candidate checks
	assign victim_var = rt_rd_var;
	assign pinned     = (victim_var == item_q.pin_result_var)
		|| (item_q.pin_op1_valid && (victim_var == item_q.pin_op1_var))
		|| (item_q.pin_op2_valid && (victim_var == item_q.pin_op2_var));
	assign victim_adv = (victim_q >= REG_W'(LAST_REG)) ? REG_W'(FIRST_REG)
		: victim_q + REG_W'(1);

	// reverse table is read at the pointer value of the next cycle
	assign rt_rd_addr = RIDX_W'(victim_d - REG_W'(FIRST_REG));
	assign rt_wr_addr = RIDX_W'(reg_sel_q - REG_W'(FIRST_REG));

	// state register and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_free_q <= PTR_W'(FIRST_REG);
			victim_q    <= REG_W'(FIRST_REG);
			steps_q     <= '0;
			scan_q      <= '0;
		end else begin
			state_q     <= state_d;
			next_free_q <= next_free_d;
			victim_q    <= victim_d;
			steps_q     <= steps_d;
			scan_q      <= scan_d;
		end
	end

	// request and selected register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd.item;
		end
		reg_sel_q <= reg_sel_d;
	end

	// sequencer: next state, table accesses, events
	always_comb begin
		state_d     = state_q;
		reg_sel_d   = reg_sel_q;
		next_free_d = next_free_q;
		victim_d    = victim_q;
		steps_d     = steps_q;
		scan_d      = scan_q;
		vt_ctl      = '0;
		vt_rd_addr  = scan_q;
		vt_clr_addr = VIDX_W'(victim_var);
		rt_wr_en    = 1'b0;
		emit        = 1'b0;
		ev_item     = '{event_kind: EV_GRANT, event_var: item_q.var_id,
			event_reg: reg_sel_q, last: 1'b0};

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vt_ctl.rd_en = 1'b1;
					vt_rd_addr   = VIDX_W'(cmd.item.var_id);
					scan_d       = '0;
					state_d      = (cmd.item.command == CMD_FLUSH) ? ST_FL_RD : ST_LOOK;
				end
			end
			ST_LOOK: begin
				steps_d = '0;
				if (var_out_of_range) begin
					ev_item.event_reg = '0;
					ev_item.last      = 1'b1;
					emit              = slot_free;
					if (slot_free) state_d = ST_IDLE;
				end else if (vt_rd_mapped) begin
					ev_item.event_reg = vt_rd_reg;
					ev_item.last      = 1'b1;
					emit              = slot_free;
					if (slot_free) state_d = ST_IDLE;
				end else if (next_free_q <= PTR_W'(LAST_REG)) begin
					reg_sel_d   = next_free_q[REG_W-1:0];
					next_free_d = next_free_q + PTR_W'(1);
					state_d     = ST_LOAD;
				end else begin
					state_d = ST_VICTIM;
				end
			end
			ST_VICTIM: begin
				if (pinned && (steps_q < MAX_VICTIM_STEPS)) begin
					victim_d = victim_adv;
					steps_d  = steps_q + PTR_W'(1);
				end else begin
					ev_item.event_kind = EV_STORE;
					ev_item.event_var  = victim_var;
					ev_item.event_reg  = victim_q;
					emit               = slot_free;
					if (slot_free) begin
						vt_ctl.clr_en = PTR_W'(victim_var) < PTR_W'(NUM_VARS);
						reg_sel_d     = victim_q;
						victim_d      = victim_adv;
						state_d       = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				ev_item.event_kind = EV_LOAD;
				emit               = slot_free;
				if (slot_free) begin
					vt_ctl.wr_en = 1'b1;
					rt_wr_en     = 1'b1;
					state_d      = ST_GRANT;
				end
			end
			ST_GRANT: begin
				ev_item.last = 1'b1;
				emit         = slot_free;
				if (slot_free) state_d = ST_IDLE;
			end
			ST_FL_RD: begin
				vt_ctl.rd_en = 1'b1;
				state_d      = ST_FL_CHK;
			end
			ST_FL_CHK: begin
				ev_item.event_kind = EV_STORE;
				ev_item.event_var  = VAR_W'(scan_q);
				ev_item.event_reg  = vt_rd_reg;
				emit               = vt_rd_mapped && slot_free;
				if (!vt_rd_mapped || slot_free) begin
					if (scan_q == VIDX_W'(NUM_VARS - 1)) begin
						state_d = ST_FL_DONE;
					end else begin
						scan_d  = scan_q + VIDX_W'(1);
						state_d = ST_FL_RD;
					end
				end
			end
			ST_FL_DONE: begin
				ev_item = '{event_kind: EV_FLUSH_DONE, event_var: '0,
					event_reg: '0, last: 1'b1};
				emit    = slot_free;
				if (slot_free) begin
					vt_ctl.clr_all = 1'b1;
					next_free_d    = PTR_W'(FIRST_REG);
					victim_d       = REG_W'(FIRST_REG);
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit) begin
			oval_q <= 1'b1;
		end else if (evt.ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oitem_q <= ev_item;
		end
	end

	assign evt.valid = oval_q;
	assign evt.item  = oitem_q;

	rmrr_var_table #(
		.NUM_VARS (NUM_VARS),
		.VIDX_W   (VIDX_W)
	) u_var_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (vt_ctl),
		.rd_addr   (vt_rd_addr),
		.wr_addr   (var_idx),
		.wr_reg    (reg_sel_q),
		.clr_addr  (vt_clr_addr),
		.rd_mapped (vt_rd_mapped),
		.rd_reg    (vt_rd_reg)
	);

	rmrr_reg_table #(
		.NUM_REGS (NUM_REGS),
		.RIDX_W   (RIDX_W)
	) u_reg_table (
		.clk     (clk),
		.wr_en   (rt_wr_en),
		.wr_addr (rt_wr_addr),
		.wr_var  (item_q.var_id),
		.rd_addr (rt_rd_addr),
		.rd_var  (rt_rd_var)
	);

	// checks
	`RMRR_ASSERT(a_free_ptr_range, next_free_q <= PTR_W'(LAST_REG + 1), "free pointer past end")
	`RMRR_ASSERT(a_steps_bound, steps_q <= MAX_VICTIM_STEPS, "victim search overran")
	`RMRR_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "accepted item not started")
	`RMRR_ASSERT_NEXT(a_last_ends_item, emit && ev_item.last, state_q == ST_IDLE, "last not ending")
	`RMRR_ASSERT_NEXT(a_spill_then_load, emit && state_q == ST_VICTIM, state_q == ST_LOAD, "no load")

endmodule

`default_nettype wire
